[src/assert_macros.svh]
// Assertion macros shared by the voter RTL.
// No dependencies; included by every module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define SGV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sgv: assertion failed");
// Same-cycle implication checked outside reset.
`define SGV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgv: implication failed");
`else
`define SGV_ASSERT(label, clk, rst_n, prop)
`define SGV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

[src/sgv_pkg.sv]
// Package for the swipe gesture voter: direction codes, register map,
// register widths and reset values, and structs passed between modules.
package sgv_pkg;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_LEFT  = 3'd4
  } dir_t;

  localparam int DIR_W = 3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_SPACING  = 2'd0,
    REG_MIN_MOVE       = 2'd1,
    REG_VOTE_THRESHOLD = 2'd2,
    REG_LOCKOUT_POLLS  = 2'd3
  } cfg_reg_t;

  localparam int SPACING_W = 8;
  localparam int MOVE_W    = 31;
  localparam int THR_W     = 4;
  localparam int POLLS_W   = 8;

  localparam logic [SPACING_W-1:0] SPACING_RST = 8'd1;
  localparam logic [MOVE_W-1:0]    MOVE_RST    = 31'd655;
  localparam logic [THR_W-1:0]     THR_RST     = 4'd6;
  localparam logic [POLLS_W-1:0]   POLLS_RST   = 8'd8;

  // Per-item request from the datapath to the poll/lockout logic
  typedef struct packed {
    logic step;      // an item leaves the input register this cycle
    logic kept;      // it passed the frame gate
    dir_t vote_dir;  // vote outcome on a kept frame
  } poll_req_t;

  // Contents of the result register
  typedef struct packed {
    dir_t gesture;
    logic frame_used;
    dir_t step_dir;
  } result_t;

endpackage

[src/sgv_in_if.sv]
// Input channel: one tracked position per transaction.
// Depends on nothing but its POS_BITS parameter.
interface sgv_in_if #(
  parameter int POS_BITS = 32
) ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

[src/sgv_out_if.sv]
// Result channel: reported gesture and per-frame status.
// Depends on sgv_pkg for the field widths.
interface sgv_out_if import sgv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] gesture;
  logic             frame_used;
  logic [DIR_W-1:0] step_dir;

  modport source (output valid, output gesture, output frame_used, output step_dir,
                  input ready);
  modport sink   (input valid, input gesture, input frame_used, input step_dir,
                  output ready);
endinterface

[src/sgv_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on sgv_pkg for the field widths.
interface sgv_cfg_if import sgv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/swipe_gesture_voter.sv]
// Top level of the swipe gesture voter: handshakes, configuration registers,
// frame gate, input and result registers. Depends on sgv_pkg, the three
// channel interfaces, sgv_classify, sgv_vote, sgv_lockout, assert_macros.svh.
//
//  channel | direction | payload                          | accepted when
//  in_if   | sink      | pos_x, pos_y                     | valid && ready
//  out_if  | source    | gesture, frame_used, step_dir    | valid && ready
//  cfg_if  | sink      | index, data                      | valid (ready held high)
//
// One result per item, passing through the input register and then the result
// register; a new item may be accepted every cycle while the output is not stalled.
// Classification, vote and poll all sit between the two registers and use
// the state left by the previous item, so there is no hazard between items.
// Reset (rst_n low, synchronous) clears valid flags and datapath state and restores register defaults.
// An output stall backs up into in_if.ready only once both registers are full.
`include "assert_macros.svh"
module swipe_gesture_voter import sgv_pkg::*; #(
  parameter int WINDOW_LEN = 8,
  parameter int POS_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sgv_in_if.sink    in_if,
  sgv_out_if.source out_if,
  sgv_cfg_if.sink   cfg_if
);

  // Configuration registers
  logic [SPACING_W-1:0] spacing_r;
  logic [MOVE_W-1:0]    min_move_r;
  logic [THR_W-1:0]     thr_r;
  logic [POLLS_W-1:0]   polls_r;

  // Pipeline
  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [POS_BITS-1:0] s1_x_r, s1_y_r;
  logic                       out_valid_r, out_valid_nxt;
  result_t                    out_r;
  logic                       in_acc, adv;

  // Datapath state
  logic [SPACING_W-1:0]       frame_cnt_r, fc_inc;
  logic signed [POS_BITS-1:0] last_x_r, last_y_r;
  logic                       kept;
  dir_t                       raw_dir, hit, gesture;
  poll_req_t                  preq;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r  <= SPACING_RST;
      min_move_r <= MOVE_RST;
      thr_r      <= THR_RST;
      polls_r    <= POLLS_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_FRAME_SPACING:  spacing_r  <= cfg_if.data[SPACING_W-1:0];
        REG_MIN_MOVE:       min_move_r <= cfg_if.data[MOVE_W-1:0];
        REG_VOTE_THRESHOLD: thr_r      <= cfg_if.data[THR_W-1:0];
        REG_LOCKOUT_POLLS:  polls_r    <= cfg_if.data[POLLS_W-1:0];
      endcase
    end
  end

  // Handshake control
  assign adv          = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || adv;
  assign in_acc       = in_if.valid && in_if.ready;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r <= in_if.pos_x;
      s1_y_r <= in_if.pos_y;
    end
  end

  // Frame gate
  assign fc_inc = frame_cnt_r + SPACING_W'(1);
  assign kept   = fc_inc >= spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
    end else if (adv) begin
      frame_cnt_r <= kept ? '0 : fc_inc;
      if (kept) begin
        last_x_r <= s1_x_r;
        last_y_r <= s1_y_r;
      end
    end
  end

  sgv_classify #(.POS_BITS(POS_BITS)) u_classify (
    .pos_x    (s1_x_r),
    .pos_y    (s1_y_r),
    .last_x   (last_x_r),
    .last_y   (last_y_r),
    .min_move (min_move_r),
    .dir      (raw_dir)
  );

  sgv_vote #(.WINDOW_LEN(WINDOW_LEN)) u_vote (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (adv && kept),
    .code           (raw_dir),
    .vote_threshold (thr_r),
    .hit            (hit)
  );

  assign preq.step     = adv;
  assign preq.kept     = kept;
  assign preq.vote_dir = hit;

  sgv_lockout u_lockout (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (preq),
    .lockout_polls (polls_r),
    .gesture       (gesture)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.gesture    <= gesture;
      out_r.frame_used <= kept;
      out_r.step_dir   <= kept ? raw_dir : DIR_NONE;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.gesture    = out_r.gesture;
  assign out_if.frame_used = out_r.frame_used;
  assign out_if.step_dir   = out_r.step_dir;

  `SGV_ASSERT(a_adv_fills_out, clk, rst_n, adv |=> out_valid_r)
  `SGV_ASSERT(a_drop_no_dir, clk, rst_n, (adv && !kept) |=> (!out_r.frame_used && out_r.step_dir == DIR_NONE))

endmodule

[src/sgv_classify.sv]
// Direction classifier: delta to the last kept position, dominant axis,
// threshold against min_move. Pure combinational; depends on sgv_pkg.
module sgv_classify import sgv_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic signed [POS_BITS-1:0] pos_x,
  input  logic signed [POS_BITS-1:0] pos_y,
  input  logic signed [POS_BITS-1:0] last_x,
  input  logic signed [POS_BITS-1:0] last_y,
  input  logic [MOVE_W-1:0]          min_move,
  output dir_t                       dir
);

  // Room for a delta, its magnitude and the negated threshold
  localparam int CW = (POS_BITS + 2 > MOVE_W + 2) ? POS_BITS + 2 : MOVE_W + 2;

  logic signed [CW-1:0] dx, dy, ax, ay, m, neg_m;

  assign dx    = CW'(pos_x) - CW'(last_x);
  assign dy    = CW'(pos_y) - CW'(last_y);
  assign ax    = dx[CW-1] ? -dx : dx;
  assign ay    = dy[CW-1] ? -dy : dy;
  assign m     = signed'(CW'(min_move));
  assign neg_m = -m;

  // x axis wins ties
  always_comb begin
    priority if (ax >= ay) begin
      priority if (dx >= m)     dir = DIR_LEFT;
      else if (dx <= neg_m)     dir = DIR_RIGHT;
      else                      dir = DIR_NONE;
    end else begin
      priority if (dy >= m)     dir = DIR_UP;
      else if (dy <= neg_m)     dir = DIR_DOWN;
      else                      dir = DIR_NONE;
    end
  end

endmodule

[src/sgv_vote.sv]
// Vote window: shift register of recent codes with running per-direction
// counts and the threshold decision. Depends on sgv_pkg, assert_macros.svh.
`include "assert_macros.svh"
module sgv_vote import sgv_pkg::*; #(
  parameter int WINDOW_LEN = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dir_t             code,
  input  logic [THR_W-1:0] vote_threshold,
  output dir_t             hit
);

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  dir_t             win_r   [WINDOW_LEN];
  logic [CNT_W-1:0] cnt_r   [4];
  logic [CNT_W-1:0] cnt_nxt [4];
  logic [3:0]       reach;

  // Counts after the new code enters and the oldest drops out
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt_nxt[k] = cnt_r[k]
                 + CNT_W'(code == dir_t'(3'(k + 1)))
                 - CNT_W'(win_r[WINDOW_LEN-1] == dir_t'(3'(k + 1)));
      reach[k]   = CMP_W'(cnt_nxt[k]) >= CMP_W'(vote_threshold);
    end
  end

  // Priority up, right, down, left
  always_comb begin
    priority if (reach[0]) hit = DIR_UP;
    else if (reach[1])     hit = DIR_RIGHT;
    else if (reach[2])     hit = DIR_DOWN;
    else if (reach[3])     hit = DIR_LEFT;
    else                   hit = DIR_NONE;
  end

  // Window and counts; a declared gesture clears both
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= DIR_NONE;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
    end else if (push) begin
      if (hit != DIR_NONE) begin
        for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= DIR_NONE;
        for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
      end else begin
        win_r[0] <= code;
        for (int i = 1; i < WINDOW_LEN; i++) win_r[i] <= win_r[i-1];
        for (int k = 0; k < 4; k++) cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  `SGV_ASSERT(a_clear_on_hit, clk, rst_n, (push && hit != DIR_NONE) |=> (win_r[0] == DIR_NONE && cnt_r[0] == '0 && cnt_r[1] == '0 && cnt_r[2] == '0 && cnt_r[3] == '0))
  `SGV_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, ((CNT_W+2)'(cnt_r[0]) + (CNT_W+2)'(cnt_r[1]) + (CNT_W+2)'(cnt_r[2]) + (CNT_W+2)'(cnt_r[3])) <= (CNT_W+2)'(WINDOW_LEN))

endmodule

[src/sgv_lockout.sv]
// Pending gesture and post-report lockout: each item polls the pending
// gesture. Depends on sgv_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sgv_lockout import sgv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  poll_req_t          req,
  input  logic [POLLS_W-1:0] lockout_polls,
  output dir_t               gesture
);

  dir_t               pending_r, pending_nxt, pend_cur;
  logic               active_r, active_nxt;
  logic [POLLS_W-1:0] count_r, count_nxt;
  logic [POLLS_W:0]   count_inc;

  // A kept frame overwrites the pending gesture before the poll
  assign pend_cur  = req.kept ? req.vote_dir : pending_r;
  assign count_inc = {1'b0, count_r} + (POLLS_W+1)'(1);
  assign gesture   = (req.step && !active_r) ? pend_cur : DIR_NONE;

  always_comb begin
    pending_nxt = pending_r;
    active_nxt  = active_r;
    count_nxt   = count_r;
    if (req.step) begin
      if (active_r) begin
        pending_nxt = pend_cur;
        if (count_inc > {1'b0, lockout_polls}) begin
          count_nxt  = '0;
          active_nxt = 1'b0;
        end else begin
          count_nxt = count_inc[POLLS_W-1:0];
        end
      end else begin
        pending_nxt = DIR_NONE;
        active_nxt  = (pend_cur != DIR_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= DIR_NONE;
      active_r  <= 1'b0;
      count_r   <= '0;
    end else begin
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      count_r   <= count_nxt;
    end
  end

  `SGV_ASSERT(a_lock_after_report, clk, rst_n, $rose(active_r) |-> $past(gesture != DIR_NONE))

endmodule
